>>> src/ppp_pkg.sv
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared types and constants of the perspective point projector.
// ----------------------------------------------------------------------------
package ppp_pkg;

  localparam int ANG_WIDTH  = 16;
  localparam int ANG_FRAC   = 14;
  localparam int FIFO_DEPTH = 4;

  localparam logic signed [ANG_WIDTH-1:0] ANG_ONE = 16'sd16384;

  typedef enum logic {
    OP_POINT,
    OP_RECT
  } op_t;

  typedef enum logic [2:0] {
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_EYE_DISTANCE,
    REG_COS_ANGLE,
    REG_SIN_ANGLE
  } reg_index_t;

  typedef enum logic [1:0] {
    CORNER_TL,
    CORNER_TR,
    CORNER_BR,
    CORNER_BL
  } corner_t;

  typedef enum logic {
    FR_IDLE,
    FR_RECT
  } fr_state_t;

  // Per-point control that follows the coordinates down the pipeline
  typedef struct packed {
    corner_t corner;
    logic    last;
  } pt_tag_t;

endpackage

>>> src/perspective_point_projector_unit.sv
// ----------------------------------------------------------------------------
// perspective_point_projector_unit
// Perspective projection of points and rectangle corners with x-axis tilt.
// ----------------------------------------------------------------------------
// A point item gives one result, a rectangle item four (TL, TR, BR, BL, the
// last one marked). The front end takes one point item per cycle while the
// queue has room; a rectangle item holds off the input until its last
// corner is sent, the corner sequencer sending one corner point a cycle
// into a four-entry queue while it has room. The back end is a fully
// pipelined datapath that retires one projected point per cycle, but the
// whole back end holds while a result waits on the output. The divider has
// one compare-subtract stage per quotient bit (COORD_WIDTH + 1 stages).
module perspective_point_projector_unit #(
  parameter int COORD_WIDTH = 24,
  parameter int FRAC_BITS   = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // pos_x, pos_y, pos_z, rect_width, rect_height
  input  logic [((5*COORD_WIDTH-2+7)/8)*8-1:0]   s_axis_tdata,
  // op
  input  logic                                   s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // out_x, out_y
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0]     m_axis_tdata,
  // corner
  output logic [1:0]                             m_axis_tuser,
  output logic                                   m_axis_tlast,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [2:0]                             cfg_index,
  input  logic [COORD_WIDTH-1:0]                 cfg_data
);

  localparam int W      = COORD_WIDTH;
  localparam int XW     = W + 1;
  localparam int AW     = ppp_pkg::ANG_WIDTH;
  localparam int OUT_DW = ((2*W+7)/8)*8;
  localparam int TGW    = $bits(ppp_pkg::pt_tag_t);
  localparam int FW     = TGW + W + 2*XW;

  localparam logic [W-2:0] EYE_RESET = (W-1)'(64'd1024 << FRAC_BITS);

  logic signed [W-1:0]  mid_x, mid_y;
  logic        [W-2:0]  eye_distance;
  logic signed [AW-1:0] cos_angle, sin_angle;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_x        <= '0;
      mid_y        <= '0;
      eye_distance <= EYE_RESET;
      cos_angle    <= ppp_pkg::ANG_ONE;
      sin_angle    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ppp_pkg::REG_CENTER_X:     mid_x        <= cfg_data;
        ppp_pkg::REG_CENTER_Y:     mid_y        <= cfg_data;
        ppp_pkg::REG_EYE_DISTANCE: eye_distance <= cfg_data[W-2:0];
        ppp_pkg::REG_COS_ANGLE:    cos_angle    <= cfg_data[AW-1:0];
        ppp_pkg::REG_SIN_ANGLE:    sin_angle    <= cfg_data[AW-1:0];
        default: ;
      endcase
    end
  end

  logic                  f_valid, f_ready;
  logic signed [XW-1:0]  f_x, f_y;
  logic signed [W-1:0]   f_z;
  ppp_pkg::pt_tag_t      f_tag;

  ppp_front #(.COORD_WIDTH(W)) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_valid       (s_axis_tvalid),
    .s_ready       (s_axis_tready),
    .s_op          (ppp_pkg::op_t'(s_axis_tuser)),
    .s_pos_x       (s_axis_tdata[W-1:0]),
    .s_pos_y       (s_axis_tdata[2*W-1:W]),
    .s_pos_z       (s_axis_tdata[3*W-1:2*W]),
    .s_rect_width  (s_axis_tdata[4*W-2:3*W]),
    .s_rect_height (s_axis_tdata[5*W-3:4*W-1]),
    .p_valid       (f_valid),
    .p_ready       (f_ready),
    .p_x           (f_x),
    .p_y           (f_y),
    .p_z           (f_z),
    .p_tag         (f_tag)
  );

  logic           q_valid, q_ready;
  logic [FW-1:0]  q_data;

  ppp_fifo #(.WIDTH(FW)) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  ({f_tag, f_z, f_y, f_x}),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  logic signed [W-1:0] o_x, o_y;
  ppp_pkg::pt_tag_t    o_tag;

  ppp_back #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .mid_x        (mid_x),
    .mid_y        (mid_y),
    .eye_distance (eye_distance),
    .cos_angle    (cos_angle),
    .sin_angle    (sin_angle),
    .in_valid     (q_valid),
    .in_ready     (q_ready),
    .in_x         (q_data[XW-1:0]),
    .in_y         (q_data[2*XW-1:XW]),
    .in_z         (q_data[2*XW+W-1:2*XW]),
    .in_tag       (q_data[FW-1:2*XW+W]),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_x        (o_x),
    .out_y        (o_y),
    .out_tag      (o_tag)
  );

  assign m_axis_tdata = OUT_DW'({o_y, o_x});
  assign m_axis_tuser = o_tag.corner;
  assign m_axis_tlast = o_tag.last;

endmodule

>>> src/ppp_front.sv
// ----------------------------------------------------------------------------
// ppp_front
// Accepts input items, passes points on and expands a rectangle into its
// four corner points, one per cycle while p_ready is high.
// ----------------------------------------------------------------------------
module ppp_front #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_valid,
  output logic                          s_ready,
  input  ppp_pkg::op_t                  s_op,
  input  logic signed [COORD_WIDTH-1:0] s_pos_x,
  input  logic signed [COORD_WIDTH-1:0] s_pos_y,
  input  logic signed [COORD_WIDTH-1:0] s_pos_z,
  input  logic        [COORD_WIDTH-2:0] s_rect_width,
  input  logic        [COORD_WIDTH-2:0] s_rect_height,
  output logic                          p_valid,
  input  logic                          p_ready,
  output logic signed [COORD_WIDTH:0]   p_x,
  output logic signed [COORD_WIDTH:0]   p_y,
  output logic signed [COORD_WIDTH-1:0] p_z,
  output ppp_pkg::pt_tag_t              p_tag
);

  localparam int W  = COORD_WIDTH;
  localparam int XW = W + 1;

  ppp_pkg::fr_state_t state, state_next;
  ppp_pkg::corner_t   k, k_next;
  logic signed [W-1:0] bx, by;
  logic        [W-2:0] bw, bh;
  logic                load;
  logic                add_w, add_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppp_pkg::FR_IDLE;
      k     <= ppp_pkg::CORNER_TL;
    end else begin
      state <= state_next;
      k     <= k_next;
    end
  end

  // Hold the rectangle while its corners are sent
  always_ff @(posedge clk) begin
    if (load) begin
      bx <= s_pos_x;
      by <= s_pos_y;
      bw <= s_rect_width;
      bh <= s_rect_height;
    end
  end

  assign add_w = (k == ppp_pkg::CORNER_TR) || (k == ppp_pkg::CORNER_BR);
  assign add_h = (k == ppp_pkg::CORNER_BR) || (k == ppp_pkg::CORNER_BL);

  always_comb begin
    state_next   = state;
    k_next       = k;
    load         = 1'b0;
    s_ready      = 1'b0;
    p_valid      = 1'b0;
    p_x          = XW'(s_pos_x);
    p_y          = XW'(s_pos_y);
    p_z          = s_pos_z;
    p_tag.corner = ppp_pkg::CORNER_TL;
    p_tag.last   = 1'b1;
    unique case (state)
      ppp_pkg::FR_IDLE: begin
        s_ready = p_ready;
        p_valid = s_valid;
        if (s_op == ppp_pkg::OP_RECT) begin
          p_z        = '0;
          p_tag.last = 1'b0;
          if (s_valid && p_ready) begin
            load       = 1'b1;
            state_next = ppp_pkg::FR_RECT;
            k_next     = ppp_pkg::CORNER_TR;
          end
        end
      end
      ppp_pkg::FR_RECT: begin
        p_valid      = 1'b1;
        p_x          = add_w ? XW'(bx) + XW'({1'b0, bw}) : XW'(bx);
        p_y          = add_h ? XW'(by) + XW'({1'b0, bh}) : XW'(by);
        p_z          = '0;
        p_tag.corner = k;
        p_tag.last   = (k == ppp_pkg::CORNER_BL);
        if (p_ready) begin
          k_next = ppp_pkg::corner_t'(k + 2'd1);
          if (k == ppp_pkg::CORNER_BL) begin
            state_next = ppp_pkg::FR_IDLE;
          end
        end
      end
      default: begin
        state_next = ppp_pkg::FR_IDLE;
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == ppp_pkg::FR_RECT) |-> !s_ready)
    else $error("input taken while a rectangle is expanding");

  assert property (@(posedge clk) disable iff (rst)
    (p_valid && p_tag.last) |->
      (p_tag.corner == ppp_pkg::CORNER_TL || p_tag.corner == ppp_pkg::CORNER_BL))
    else $error("last mark on a middle corner");

  assert property (@(posedge clk) disable iff (rst)
    (p_valid && p_ready && state == ppp_pkg::FR_RECT && p_tag.last)
      |=> (state == ppp_pkg::FR_IDLE))
    else $error("expander did not return to idle after the last corner");

endmodule

>>> src/ppp_fifo.sv
// ----------------------------------------------------------------------------
// ppp_fifo
// Short queue of expanded points between the front end and the pipeline.
// ----------------------------------------------------------------------------
module ppp_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int DEPTH = ppp_pkg::FIFO_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CNTW  = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CNTW-1:0]  count;
  logic             wr_en, rd_en;

  assign wr_ready = (count != CNTW'(DEPTH));
  assign rd_valid = (count != '0);
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNTW'(wr_en) - CNTW'(rd_en);
    end
  end

endmodule

>>> src/ppp_back.sv
// ----------------------------------------------------------------------------
// ppp_back
// Projection pipeline: centre offset, x-axis rotation, depth, scale by
// eye distance over depth through a pipelined divider, saturated output.
// ----------------------------------------------------------------------------
module ppp_back #(
  parameter int COORD_WIDTH = 24,
  parameter int FRAC_BITS   = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic signed [COORD_WIDTH-1:0]          mid_x,
  input  logic signed [COORD_WIDTH-1:0]          mid_y,
  input  logic        [COORD_WIDTH-2:0]          eye_distance,
  input  logic signed [ppp_pkg::ANG_WIDTH-1:0]   cos_angle,
  input  logic signed [ppp_pkg::ANG_WIDTH-1:0]   sin_angle,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [COORD_WIDTH:0]            in_x,
  input  logic signed [COORD_WIDTH:0]            in_y,
  input  logic signed [COORD_WIDTH-1:0]          in_z,
  input  ppp_pkg::pt_tag_t                       in_tag,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [COORD_WIDTH-1:0]          out_x,
  output logic signed [COORD_WIDTH-1:0]          out_y,
  output ppp_pkg::pt_tag_t                       out_tag
);

  localparam int W  = COORD_WIDTH;
  localparam int AW = ppp_pkg::ANG_WIDTH;
  localparam int AF = ppp_pkg::ANG_FRAC;
  localparam int RW = W + 2;          // offset coordinate
  localparam int PW = RW + AW + 1;    // rotation sums
  localparam int RM = PW - AF;        // rotated magnitude
  localparam int RS = RM + 1;         // rotated signed
  localparam int DW = RS;             // depth
  localparam int NW = RM + W - 1;     // dividend
  localparam int QB = W + 1;          // quotient bits
  localparam int CW = NW + 3;         // divider compare width
  localparam int VW = QB + 3;         // signed result before saturation

  localparam logic [DW-1:0] ONE  = {{(DW-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic [PW-1:0] HALF = {{(PW-1){1'b0}}, 1'b1} << (AF - 1);
  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  function automatic logic signed [RS-1:0] rnd_rot(input logic signed [PW-1:0] v);
    logic [PW-1:0] m;
    logic [PW-1:0] t;
    logic [RS-1:0] r;
    m = v[PW-1] ? -v : v;
    t = (m + HALF) >> AF;
    r = {1'b0, t[RM-1:0]};
    return v[PW-1] ? -r : r;
  endfunction

  function automatic logic signed [W-1:0] finish(input logic [QB:0] q, input logic neg,
                                                 input logic ovf,
                                                 input logic signed [W-1:0] c);
    logic signed [VW-1:0] v;
    v = $signed({2'b00, q});
    if (neg) begin
      v = -v;
    end
    v = v + VW'(c);
    if (ovf) begin
      return neg ? SMIN : SMAX;
    end else if (v > VW'(SMAX)) begin
      return SMAX;
    end else if (v < VW'(SMIN)) begin
      return SMIN;
    end
    return v[W-1:0];
  endfunction

  logic adv;
  assign adv      = !(out_valid && !out_ready);
  assign in_ready = adv;

  // offset from centre
  logic                  a_valid;
  logic signed [RW-1:0]  a_rx, a_ry;
  logic signed [W-1:0]   a_z;
  ppp_pkg::pt_tag_t      a_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_rx  <= RW'(in_x) - RW'(mid_x);
      a_ry  <= RW'(in_y) - RW'(mid_y);
      a_z   <= in_z;
      a_tag <= in_tag;
    end
  end

  // rotation products
  logic                     b_valid;
  logic signed [RW-1:0]     b_rx;
  logic signed [RW+AW-1:0]  b_rc, b_rs;
  logic signed [W+AW-1:0]   b_zs, b_zc;
  ppp_pkg::pt_tag_t         b_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_rx  <= a_rx;
      b_rc  <= a_ry * cos_angle;
      b_rs  <= a_ry * sin_angle;
      b_zs  <= a_z * sin_angle;
      b_zc  <= a_z * cos_angle;
      b_tag <= a_tag;
    end
  end

  // rotated y and z, rounded back to coordinate scale
  logic                  c_valid;
  logic signed [RW-1:0]  c_rx;
  logic signed [RS-1:0]  c_roty, c_rotz;
  ppp_pkg::pt_tag_t      c_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_rx   <= b_rx;
      c_roty <= rnd_rot(PW'(b_rc) - PW'(b_zs));
      c_rotz <= rnd_rot(PW'(b_rs) + PW'(b_zc));
      c_tag  <= b_tag;
    end
  end

  // depth and magnitudes
  logic                   d_valid;
  logic [RM-1:0]          d_magx, d_magy;
  logic                   d_negx, d_negy;
  logic [DW-1:0]          d_dep;
  ppp_pkg::pt_tag_t       d_tag;
  logic signed [RS:0]     dep_raw;
  logic [RW-1:0]          rx_abs;
  logic [RS-1:0]          ry_abs;

  assign dep_raw = (RS + 1)'($signed({1'b0, eye_distance})) - (RS + 1)'(c_rotz);
  assign rx_abs  = c_rx[RW-1] ? -c_rx : c_rx;
  assign ry_abs  = c_roty[RS-1] ? -c_roty : c_roty;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (adv) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_magx <= RM'(rx_abs);
      d_magy <= ry_abs[RM-1:0];
      d_negx <= c_rx[RW-1];
      d_negy <= c_roty[RS-1];
      d_dep  <= (dep_raw < $signed({1'b0, ONE})) ? ONE : dep_raw[DW-1:0];
      d_tag  <= c_tag;
    end
  end

  // dividends: magnitude times eye distance
  logic              e_valid;
  logic [NW-1:0]     e_nx, e_ny;
  logic              e_negx, e_negy;
  logic [DW-1:0]     e_dep;
  ppp_pkg::pt_tag_t  e_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (adv) begin
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_nx   <= d_magx * eye_distance;
      e_ny   <= d_magy * eye_distance;
      e_negx <= d_negx;
      e_negy <= d_negy;
      e_dep  <= d_dep;
      e_tag  <= d_tag;
    end
  end

  // divider: one restoring step per stage, most significant quotient bit first
  logic              dv_valid [0:QB];
  logic [CW-1:0]     dv_rx    [0:QB];
  logic [CW-1:0]     dv_ry    [0:QB];
  logic [QB-1:0]     dv_qx    [0:QB];
  logic [QB-1:0]     dv_qy    [0:QB];
  logic [DW-1:0]     dv_d     [0:QB];
  logic              dv_ovx   [0:QB];
  logic              dv_ovy   [0:QB];
  logic              dv_nx    [0:QB];
  logic              dv_ny    [0:QB];
  ppp_pkg::pt_tag_t  dv_tag   [0:QB];
  logic [CW-1:0]     d_lim;

  assign d_lim = CW'(e_dep) << QB;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else if (adv) begin
      dv_valid[0] <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_rx[0]  <= CW'(e_nx);
      dv_ry[0]  <= CW'(e_ny);
      dv_qx[0]  <= '0;
      dv_qy[0]  <= '0;
      dv_d[0]   <= e_dep;
      dv_ovx[0] <= CW'(e_nx) >= d_lim;
      dv_ovy[0] <= CW'(e_ny) >= d_lim;
      dv_nx[0]  <= e_negx;
      dv_ny[0]  <= e_negy;
      dv_tag[0] <= e_tag;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int SH = QB - 1 - j;
    logic [CW-1:0] sd;
    logic          gx, gy;

    assign sd = CW'(dv_d[j]) << SH;
    assign gx = dv_rx[j] >= sd;
    assign gy = dv_ry[j] >= sd;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[j+1] <= 1'b0;
      end else if (adv) begin
        dv_valid[j+1] <= dv_valid[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rx[j+1]  <= gx ? dv_rx[j] - sd : dv_rx[j];
        dv_ry[j+1]  <= gy ? dv_ry[j] - sd : dv_ry[j];
        dv_qx[j+1]  <= dv_qx[j] | (QB'(gx) << SH);
        dv_qy[j+1]  <= dv_qy[j] | (QB'(gy) << SH);
        dv_d[j+1]   <= dv_d[j];
        dv_ovx[j+1] <= dv_ovx[j];
        dv_ovy[j+1] <= dv_ovy[j];
        dv_nx[j+1]  <= dv_nx[j];
        dv_ny[j+1]  <= dv_ny[j];
        dv_tag[j+1] <= dv_tag[j];
      end
    end
  end

  // round to nearest on the remainder, restore sign, add centre back, saturate
  logic [QB:0] qx_rnd, qy_rnd;

  assign qx_rnd = {1'b0, dv_qx[QB]}
                + (QB + 1)'({dv_rx[QB], 1'b0} >= (CW + 1)'(dv_d[QB]));
  assign qy_rnd = {1'b0, dv_qy[QB]}
                + (QB + 1)'({dv_ry[QB], 1'b0} >= (CW + 1)'(dv_d[QB]));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_valid[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x   <= finish(qx_rnd, dv_nx[QB], dv_ovx[QB], mid_x);
      out_y   <= finish(qy_rnd, dv_ny[QB], dv_ovy[QB], mid_y);
      out_tag <= dv_tag[QB];
    end
  end

endmodule
